FILE: rtl/bptc_pkg.sv
// Shared types and constants for the barometer temperature compensation core.
// Used by every module of the block; depends on nothing else.
package bptc_pkg;

  // Field widths.
  localparam int RawW    = 24;
  localparam int CalW    = 16;
  localparam int CfgIdxW = 3;
  localparam int TempW   = 19;
  localparam int PresW   = 22;

  // Intermediate widths.
  localparam int DtW     = RawW + 1;             // D2 - C5*2^8
  localparam int CoefPW  = DtW + CalW;           // dT times a calibration word
  localparam int OffW    = 35;                   // OFF
  localparam int SensW   = 34;                   // SENS
  localparam int SplitW  = 17;                   // SENS is split at this bit
  localparam int SensHiW = SensW - SplitW;
  localparam int PartW   = RawW + SplitW;        // one partial product
  localparam int FullW   = RawW + SensW;         // D1 * SENS
  localparam int DiffW   = FullW - 21 + 1;       // scaled product minus OFF
  localparam int PresXW  = PresW + 1;            // pressure before saturation

  // Scaling constants of the compensation formulas.
  localparam int TempBase      = 2000;
  localparam int TempShift     = 23;
  localparam int RefTempShift  = 8;
  localparam int OffBaseShift  = 16;
  localparam int OffTcShift    = 7;
  localparam int SensBaseShift = 15;
  localparam int SensTcShift   = 8;
  localparam int PresShift1    = 21;
  localparam int PresShift2    = 15;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegSens       = 3'd0,
    RegOffset     = 3'd1,
    RegSensTempco = 3'd2,
    RegOffTempco  = 3'd3,
    RegRefTemp    = 3'd4,
    RegTempSlope  = 3'd5
  } cfg_reg_t;

  // Calibration words as held in configuration.
  typedef struct packed {
    logic [CalW-1:0] sens;
    logic [CalW-1:0] offset;
    logic [CalW-1:0] sens_tempco;
    logic [CalW-1:0] offset_tempco;
    logic [CalW-1:0] ref_temp;
    logic [CalW-1:0] temp_slope;
  } cal_t;

  // Request passed from the coefficient pipeline to the pressure pipeline.
  typedef struct packed {
    logic                    ok;
    logic [RawW-1:0]         d1;
    logic signed [TempW-1:0] temp;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
  } coef_t;

endpackage

FILE: rtl/bptc_cfg_regs.sv
// Calibration register file of the compensation core.
// Depends on bptc_pkg for the register indexes and the cal_t bundle.
module bptc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bptc_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [bptc_pkg::CalW-1:0]     wr_data,
  output bptc_pkg::cal_t                cal
);
  import bptc_pkg::*;

  // Decode the index and update one word; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        RegSens:       cal.sens          <= wr_data;
        RegOffset:     cal.offset        <= wr_data;
        RegSensTempco: cal.sens_tempco   <= wr_data;
        RegOffTempco:  cal.offset_tempco <= wr_data;
        RegRefTemp:    cal.ref_temp      <= wr_data;
        RegTempSlope:  cal.temp_slope    <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/bptc_coef.sv
// First three pipeline stages: temperature difference, the three dT
// products, then temperature, OFF and SENS. Depends on bptc_pkg.
module bptc_coef (
  input  logic                         clk,
  input  logic                         rst,
  input  bptc_pkg::cal_t               cal,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bptc_pkg::RawW-1:0]    d1_in,
  input  logic [bptc_pkg::RawW-1:0]    d2_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bptc_pkg::coef_t              out_data
);
  import bptc_pkg::*;

  logic                     v1, v2, v3;
  logic                     rdy1, rdy2, rdy3;
  logic                     s1_ok, s2_ok;
  logic [RawW-1:0]          s1_d1, s2_d1;
  logic signed [DtW-1:0]    s1_dt;
  logic signed [CoefPW-1:0] s2_p6, s2_p4, s2_p3;
  logic signed [DtW-1:0]    dt_next;

  // A stage moves when it is empty or the next one moves.
  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  assign dt_next = $signed({1'b0, d2_in})
                 - $signed({1'b0, cal.ref_temp, {RefTempShift{1'b0}}});

  // Stage 1: temperature difference and the missing-reading check.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_ok <= (d1_in != '0) && (d2_in != '0);
      s1_d1 <= d1_in;
      s1_dt <= dt_next;
    end
  end

  // Stage 2: the three products of dT with calibration words.
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_ok <= s1_ok;
      s2_d1 <= s1_d1;
      s2_p6 <= CoefPW'(s1_dt) * CoefPW'($signed({1'b0, cal.temp_slope}));
      s2_p4 <= CoefPW'(s1_dt) * CoefPW'($signed({1'b0, cal.offset_tempco}));
      s2_p3 <= CoefPW'(s1_dt) * CoefPW'($signed({1'b0, cal.sens_tempco}));
    end
  end

  // Stage 3: scale the products and add the base terms.
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      out_data.ok   <= s2_ok;
      out_data.d1   <= s2_d1;
      out_data.temp <= TempW'(s2_p6 >>> TempShift) + TempW'(TempBase);
      out_data.off  <= OffW'($signed({1'b0, cal.offset, {OffBaseShift{1'b0}}}))
                     + OffW'(s2_p4 >>> OffTcShift);
      out_data.sens <= SensW'($signed({1'b0, cal.sens, {SensBaseShift{1'b0}}}))
                     + SensW'(s2_p3 >>> SensTcShift);
    end
  end

endmodule

FILE: rtl/bptc_press.sv
// Last three pipeline stages: D1 times SENS as two partial products, their
// sum, then OFF removal, scaling and saturation. Depends on bptc_pkg.
module bptc_press (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bptc_pkg::coef_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [bptc_pkg::TempW-1:0] temp_hundredths,
  output logic signed [bptc_pkg::PresW-1:0] pressure_hundredths,
  output logic                            result_valid
);
  import bptc_pkg::*;

  logic                      v4, v5;
  logic                      rdy4, rdy5, rdy6;
  logic                      s4_ok, s5_ok;
  logic signed [TempW-1:0]   s4_temp, s5_temp;
  logic signed [OffW-1:0]    s4_off, s5_off;
  logic [PartW-1:0]          s4_plo;
  logic signed [PartW-1:0]   s4_phi;
  logic signed [FullW-1:0]   s5_full;
  logic signed [DiffW-1:0]   diff;
  logic signed [PresXW-1:0]  pres_wide;
  logic signed [PresW-1:0]   pres_sat;

  // Ready chain back from the output register.
  assign rdy6     = !out_valid || !out_stall;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign in_ready = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) out_valid <= v5;
    end
  end

  // Stage 4: low half of SENS is unsigned, high half carries the sign.
  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      s4_ok   <= in_data.ok;
      s4_temp <= in_data.temp;
      s4_off  <= in_data.off;
      s4_plo  <= PartW'(in_data.d1) * PartW'(in_data.sens[SplitW-1:0]);
      s4_phi  <= PartW'($signed(in_data.sens[SensW-1:SplitW]))
               * PartW'($signed({1'b0, in_data.d1}));
    end
  end

  // Stage 5: recombine the partial products.
  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      s5_ok   <= s4_ok;
      s5_temp <= s4_temp;
      s5_off  <= s4_off;
      s5_full <= (FullW'(s4_phi) <<< SplitW) + FullW'($signed({1'b0, s4_plo}));
    end
  end

  // Stage 6 logic: remove OFF, scale, saturate to the output width.
  assign diff      = DiffW'(s5_full >>> PresShift1) - DiffW'(s5_off);
  assign pres_wide = PresXW'(diff >>> PresShift2);
  always_comb begin
    if (pres_wide[PresXW-1] != pres_wide[PresW-1]) begin
      pres_sat = pres_wide[PresXW-1] ? {1'b1, {(PresW-1){1'b0}}}
                                     : {1'b0, {(PresW-1){1'b1}}};
    end else begin
      pres_sat = pres_wide[PresW-1:0];
    end
  end

  // Output register; a missing reading gives zero values.
  always_ff @(posedge clk) begin
    if (rdy6 && v5) begin
      result_valid        <= s5_ok;
      temp_hundredths     <= s5_ok ? s5_temp : '0;
      pressure_hundredths <= s5_ok ? pres_sat : '0;
    end
  end

endmodule

FILE: rtl/baro_pressure_temp_compensation_core.sv
// Barometer first-order temperature compensation, top level.
// Depends on bptc_pkg, bptc_cfg_regs, bptc_coef and bptc_press.
//
// The core takes one raw pressure and temperature pair per request and
// returns temperature and pressure in hundredths, both signed. It is a
// six-stage pipeline: dT, three dT products, OFF/SENS, two partial products
// of D1*SENS, their sum, and the final scaling. A new request is taken every
// clock cycle unless a stalled output has filled the pipeline; its result
// passes through the six register stages, the first of which captures the
// request, and is presented from the output register. When the output is
// stalled, the pipeline fills its empty stages before it stalls the input.
// A request with either raw reading at zero gives result_valid low and zero
// values. Calibration words are written through the cfg port, which is
// always ready, and must be written while no request is in flight.
module baro_pressure_temp_compensation_core (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bptc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bptc_pkg::CalW-1:0]         cfg_data,
  // Raw readings.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bptc_pkg::RawW-1:0]         raw_pressure,
  input  logic [bptc_pkg::RawW-1:0]         raw_temperature,
  // Compensated results.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bptc_pkg::TempW-1:0] temp_hundredths,
  output logic signed [bptc_pkg::PresW-1:0] pressure_hundredths,
  output logic                              result_valid
);
  import bptc_pkg::*;

  cal_t  cal;
  logic  in_ready;
  logic  mid_valid;
  logic  mid_ready;
  coef_t mid_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  // Calibration words.
  bptc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cal      (cal)
  );

  // dT, temperature, OFF and SENS.
  bptc_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .d1_in     (raw_pressure),
    .d2_in     (raw_temperature),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // Pressure and output register.
  bptc_press u_press (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (mid_valid),
    .in_ready            (mid_ready),
    .in_data             (mid_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .temp_hundredths     (temp_hundredths),
    .pressure_hundredths (pressure_hundredths),
    .result_valid        (result_valid)
  );

endmodule

FILE: rtl/bptc_checker.sv
// Port-level checks for the compensation core, attached by bind.
// Depends on bptc_pkg for port widths.
module bptc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bptc_pkg::TempW-1:0] temp_hundredths,
  input logic signed [bptc_pkg::PresW-1:0] pressure_hundredths,
  input logic                              result_valid
);
  import bptc_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temp_hundredths)
      && $stable(pressure_hundredths) && $stable(result_valid))
    else $error("stalled result changed");

  // A missing reading shows zero values.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_valid |-> temp_hundredths == '0 && pressure_hundredths == '0)
    else $error("invalid result with nonzero values");

  // With a free output, every stage can move, so the input is never stalled.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_bptc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .temp_hundredths     (temp_hundredths),
  .pressure_hundredths (pressure_hundredths),
  .result_valid        (result_valid)
);

FILE: bench/tb_top.sv
// Self-checking bench for the barometer temperature compensation core.
// Depends on bptc_pkg and baro_pressure_temp_compensation_core; it reads no files.
module tb_top;
  import bptc_pkg::*;

  // One compensated result: temperature, pressure and the reading-present flag.
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pres;
    logic                    ok;
  } comp_reading_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [RawW-1:0] pres_raw;
    logic [RawW-1:0] temp_raw;
    bit              full_scale;
    bit              typed;
    comp_reading_t   reading;
  } dir_row_t;

  localparam int PipeLatency = 6;
  localparam int IdleLimit   = 2000;
  localparam int RawMax      = (1 << RawW) - 1;
  localparam int CalMax      = (1 << CalW) - 1;
  localparam longint PresMax = (64'sd1 <<< (PresW - 1)) - 1;
  localparam longint PresMin = -(64'sd1 <<< (PresW - 1));
  localparam int BatchSize   = 100;
  localparam int PhaseItems  = 400;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CalW-1:0]         cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RawW-1:0]         raw_pressure = '0;
  logic [RawW-1:0]         raw_temperature = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [TempW-1:0] temp_hundredths;
  logic signed [PresW-1:0] pressure_hundredths;
  logic                    result_valid;

  cal_t          cal_model = '0;
  comp_reading_t pending_readings[$];
  dir_row_t      dir_rows[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            requests_sent = 0;
  int            results_checked = 0;
  int            mismatch_count = 0;
  int            cal_loads = 0;
  int            idle_cycles = 0;

  baro_pressure_temp_compensation_core u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .raw_pressure        (raw_pressure),
    .raw_temperature     (raw_temperature),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .temp_hundredths     (temp_hundredths),
    .pressure_hundredths (pressure_hundredths),
    .result_valid        (result_valid)
  );

  always #6 clk = ~clk;

  // First-order compensation with 64-bit signed intermediates; >>> floors.
  function automatic comp_reading_t compensate(input logic [RawW-1:0] d1,
                                               input logic [RawW-1:0] d2,
                                               input cal_t c);
    comp_reading_t r;
    longint dt, temp, off, sens, p;
    r = '0;
    if (d1 == 0 || d2 == 0) return r;
    dt   = longint'(d2) - (longint'(c.ref_temp) <<< RefTempShift);
    temp = TempBase + ((dt * longint'(c.temp_slope)) >>> TempShift);
    off  = (longint'(c.offset) <<< OffBaseShift)
         + ((dt * longint'(c.offset_tempco)) >>> OffTcShift);
    sens = (longint'(c.sens) <<< SensBaseShift)
         + ((dt * longint'(c.sens_tempco)) >>> SensTcShift);
    p    = (((longint'(d1) * sens) >>> PresShift1) - off) >>> PresShift2;
    if (p > PresMax) p = PresMax;
    if (p < PresMin) p = PresMin;
    r.temp = temp[TempW-1:0];
    r.pres = p[PresW-1:0];
    r.ok   = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [RawW-1:0] p, input logic [RawW-1:0] t,
                                  input bit full, input bit typed,
                                  input int temp, input int pres, input bit ok);
    dir_row_t row;
    row.pres_raw     = p;
    row.temp_raw     = t;
    row.full_scale   = full;
    row.typed        = typed;
    row.reading.temp = temp[TempW-1:0];
    row.reading.pres = pres[PresW-1:0];
    row.reading.ok   = ok;
    dir_rows.push_back(row);
  endfunction

  // A calibration word, now and then pinned to one end of its range.
  function automatic logic [CalW-1:0] rand_word();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return CalMax[CalW-1:0];
    return CalW'($urandom_range(CalMax));
  endfunction

  // A calibration word scattered around a typical factory value.
  function automatic logic [CalW-1:0] near_word(input int base);
    int v;
    v = base + int'($urandom_range(8191)) - 4096;
    return v[CalW-1:0];
  endfunction

  function automatic cal_t pick_calibration();
    cal_t c;
    int   pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      c = '0;
    end else if (pick == 1) begin
      c = '1;
    end else if (pick < 6) begin
      c.sens          = near_word(40127);
      c.offset        = near_word(36924);
      c.sens_tempco   = near_word(23317);
      c.offset_tempco = near_word(23282);
      c.ref_temp      = near_word(33464);
      c.temp_slope    = near_word(28312);
    end else begin
      c.sens          = rand_word();
      c.offset        = rand_word();
      c.sens_tempco   = rand_word();
      c.offset_tempco = rand_word();
      c.ref_temp      = rand_word();
      c.temp_slope    = rand_word();
    end
    return c;
  endfunction

  // Raw pairs: mostly plausible temperatures near the reference, plus
  // missing readings, a zero temperature difference and range extremes.
  task automatic pick_raw_pair(output logic [RawW-1:0] p, output logic [RawW-1:0] t);
    int pick, centre, t_int;
    pick   = $urandom_range(99);
    centre = int'(cal_model.ref_temp) << RefTempShift;
    p      = RawW'($urandom_range(RawMax));
    if (pick < 4) begin
      p = '0;
      t = ($urandom_range(1) == 0) ? '0 : RawW'($urandom_range(RawMax));
    end else if (pick < 8) begin
      t = '0;
    end else if (pick < 12) begin
      t = centre[RawW-1:0];
    end else if (pick < 18) begin
      p = ($urandom_range(1) == 0) ? RawW'(1) : RawMax[RawW-1:0];
      t = ($urandom_range(1) == 0) ? RawW'(1) : RawMax[RawW-1:0];
    end else if (pick < 40) begin
      t = RawW'($urandom_range(RawMax));
    end else begin
      t_int = centre + int'($urandom_range(1 << 21)) - (1 << 20);
      if (t_int < 1) t_int = 1;
      if (t_int > RawMax) t_int = RawMax;
      t = t_int[RawW-1:0];
    end
  endtask

  // Present one request, with random idle cycles first; returns at acceptance.
  task automatic send_request(input logic [RawW-1:0] p, input logic [RawW-1:0] t,
                              input comp_reading_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= p;
    raw_temperature <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(want);
    requests_sent++;
  endtask

  // Stop sending and wait until every pending result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high so back-to-back writes stay clean.
  task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [CalW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegSens:       cal_model.sens = val;
      RegOffset:     cal_model.offset = val;
      RegSensTempco: cal_model.sens_tempco = val;
      RegOffTempco:  cal_model.offset_tempco = val;
      RegRefTemp:    cal_model.ref_temp = val;
      RegTempSlope:  cal_model.temp_slope = val;
      default: ;
    endcase
  endtask

  // Load a full calibration set while the pipeline is empty, then poke the
  // unused indexes to show they do not alias onto a real register.
  task automatic load_calibration(input cal_t c);
    settle();
    write_cal(RegSens, c.sens);
    write_cal(RegOffset, c.offset);
    write_cal(RegSensTempco, c.sens_tempco);
    write_cal(RegOffTempco, c.offset_tempco);
    write_cal(RegRefTemp, c.ref_temp);
    write_cal(RegTempSlope, c.temp_slope);
    write_cal(CfgUnusedLo, CalW'($urandom_range(CalMax)));
    write_cal(CfgUnusedHi, CalW'($urandom_range(CalMax)));
    cfg_valid <= 1'b0;
    cal_loads++;
  endtask

  // Result side: random stalls and a field-by-field compare against the oldest request.
  always @(posedge clk) begin
    comp_reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending: temp %0d pres %0d valid %0b",
                   $time, temp_hundredths, pressure_hundredths, result_valid);
        end else begin
          want = pending_readings.pop_front();
          results_checked++;
          if (temp_hundredths !== want.temp) begin
            mismatch_count++;
            $display("%0t: temp_hundredths expected %0d, got %0d",
                     $time, want.temp, temp_hundredths);
          end
          if (pressure_hundredths !== want.pres) begin
            mismatch_count++;
            $display("%0t: pressure_hundredths expected %0d, got %0d",
                     $time, want.pres, pressure_hundredths);
          end
          if (result_valid !== want.ok) begin
            mismatch_count++;
            $display("%0t: result_valid expected %0b, got %0b",
                     $time, want.ok, result_valid);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: too long without any accepted transfer ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired, %0d requests still pending",
                 $time, pending_readings.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then four idle and stall mixes of random requests.
  initial begin
    logic [RawW-1:0] p, t;
    comp_reading_t   want;
    bit              full_loaded;
    int              phase, n;

    // Reset calibration (all words zero): every valid pair gives 20.00 C and zero pressure.
    add_row(24'h000000, 24'h000000, 0, 1, 0, 0, 0);
    add_row(24'h000000, 24'hFFFFFF, 0, 1, 0, 0, 0);
    add_row(24'hFFFFFF, 24'h000000, 0, 1, 0, 0, 0);
    add_row(24'h000001, 24'h000001, 0, 1, TempBase, 0, 1);
    add_row(24'hFFFFFF, 24'hFFFFFF, 0, 1, TempBase, 0, 1);
    add_row(24'h800000, 24'h7FFFFF, 0, 1, TempBase, 0, 1);
    add_row(24'h555555, 24'hAAAAAA, 0, 1, TempBase, 0, 1);
    // Full-scale calibration: zero temperature difference and the dT extremes.
    add_row(24'hFFFFFF, 24'hFFFF00, 1, 0, 0, 0, 0);
    add_row(24'h000001, 24'hFFFF00, 1, 0, 0, 0, 0);
    add_row(24'h800000, 24'hFFFF00, 1, 0, 0, 0, 0);
    add_row(24'h000001, 24'h000001, 1, 0, 0, 0, 0);
    add_row(24'hFFFFFF, 24'h000001, 1, 0, 0, 0, 0);
    add_row(24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0, 0);
    add_row(24'h000001, 24'hFFFFFF, 1, 0, 0, 0, 0);
    add_row(24'hAAAAAA, 24'h555555, 1, 0, 0, 0, 0);
    add_row(24'h000000, 24'hFFFF00, 1, 1, 0, 0, 0);
    add_row(24'hFFFFFF, 24'h000000, 1, 1, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    full_loaded = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].full_scale && !full_loaded) begin
        load_calibration('1);
        full_loaded = 1;
      end
      want = dir_rows[i].typed ? dir_rows[i].reading
                               : compensate(dir_rows[i].pres_raw, dir_rows[i].temp_raw,
                                            cal_model);
      send_request(dir_rows[i].pres_raw, dir_rows[i].temp_raw, want);
    end

    // Random part; each batch waits for the pipeline to empty and reloads calibration.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        if (n % BatchSize == 0)
          load_calibration((phase == 0 && n == 0) ? cal_t'('0) : pick_calibration());
        pick_raw_pair(p, t);
        send_request(p, t, compensate(p, t, cal_model));
      end
    end

    settle();
    $display("Sent %0d reading pairs under %0d calibration sets, idle and stall mixes included.",
             requests_sent, cal_loads);
    $display("Compared %0d results field by field; %0d field mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
